// ===== rtl/mpq_pkg.sv =====
package mpq_pkg;

	// Default capacity of the queue
	localparam int DEPTH_DEF = 16;

	// Width of the occupancy field of a result
	localparam int OCC_W = 5;

	// Widths of the entry fields
	localparam int KEY_W = 16;
	localparam int TAG_W = 16;

	typedef enum logic {
		OP_ENQUEUE = 1'b0,
		OP_DEQUEUE = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_ENQUEUED  = 2'd0,
		ST_DEQUEUED  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_RES
	} state_t;

	// One held entry, as stored in the entry memory
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} entry_t;

	// Request beat
	typedef struct packed {
		opcode_t          opcode;
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} req_t;

	// Response beat
	typedef struct packed {
		status_t          status;
		logic [KEY_W-1:0] out_key;
		logic [TAG_W-1:0] out_tag;
		logic [OCC_W-1:0] occupancy;
	} rsp_t;

endpackage

// ===== rtl/mpq_store.sv =====
module mpq_store #(
	parameter int DEPTH = mpq_pkg::DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  mpq_pkg::entry_t  wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output mpq_pkg::entry_t  rdata
);

	mpq_pkg::entry_t mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/mpq_ctrl.sv =====
module mpq_ctrl #(
	parameter int DEPTH = mpq_pkg::DEPTH_DEF,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  mpq_pkg::req_t    req,
	output logic             res_valid,
	input  logic             res_ready,
	output mpq_pkg::rsp_t    res,
	output logic             mem_we,
	output logic [AW-1:0]    mem_waddr,
	output mpq_pkg::entry_t  mem_wdata,
	output logic             mem_re,
	output logic [AW-1:0]    mem_raddr,
	input  mpq_pkg::entry_t  mem_rdata
);

	localparam int OW = mpq_pkg::OCC_W;

	mpq_pkg::state_t  state_q, state_nxt;
	mpq_pkg::status_t status_q;
	logic [mpq_pkg::KEY_W-1:0] key_q;
	logic [mpq_pkg::TAG_W-1:0] tag_q;
	logic [CW-1:0]    count_q, count_nxt;
	logic [CW-1:0]    ptr_q;
	logic             rvalid_s1;
	logic [AW-1:0]    ridx_s1;
	logic [AW-1:0]    best_idx_q;
	mpq_pkg::entry_t  best_q;
	logic             req_fire, res_fire, pass_done, take_best;

	assign req_fire  = req_valid && req_ready;
	assign res_fire  = res_valid && res_ready;
	// A pass ends once every read is issued and the last beat has returned
	assign pass_done = (ptr_q == count_q) && !rvalid_s1;
	// Strict compare keeps the oldest of equal keys
	assign take_best = rvalid_s1 && ((ridx_s1 == '0) || (mem_rdata.key > best_q.key));

	// Next state, memory port control and result
	always_comb begin
		state_nxt = state_q;
		req_ready = 1'b0;
		res_valid = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = ptr_q[AW-1:0];
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = '{key: key_q, tag: tag_q};
		count_nxt = count_q;
		case (status_q)
			mpq_pkg::ST_ENQUEUED: count_nxt = count_q + CW'(1);
			mpq_pkg::ST_DEQUEUED: count_nxt = count_q - CW'(1);
			default:              count_nxt = count_q;
		endcase
		res.status    = status_q;
		res.out_key   = (status_q == mpq_pkg::ST_DEQUEUED) ? best_q.key : '0;
		res.out_tag   = (status_q == mpq_pkg::ST_DEQUEUED) ? best_q.tag : '0;
		res.occupancy = OW'(count_nxt);
		case (state_q)
			mpq_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req.opcode == mpq_pkg::OP_DEQUEUE && count_q != '0) begin
						state_nxt = mpq_pkg::S_SCAN;
					end else begin
						state_nxt = mpq_pkg::S_RES;
					end
				end
			end
			mpq_pkg::S_SCAN: begin
				mem_re = (ptr_q < count_q);
				if (pass_done) begin
					state_nxt = mpq_pkg::S_SHIFT;
				end
			end
			mpq_pkg::S_SHIFT: begin
				mem_re = (ptr_q < count_q);
				// Close the gap: each entry behind the winner moves down one slot
				if (rvalid_s1) begin
					mem_we    = 1'b1;
					mem_waddr = ridx_s1 - AW'(1);
					mem_wdata = mem_rdata;
				end
				if (pass_done) begin
					state_nxt = mpq_pkg::S_RES;
				end
			end
			mpq_pkg::S_RES: begin
				res_valid = 1'b1;
				if (res_ready) begin
					// Append at the tail on a successful enqueue
					mem_we    = (status_q == mpq_pkg::ST_ENQUEUED);
					state_nxt = mpq_pkg::S_IDLE;
				end
			end
			default: state_nxt = mpq_pkg::S_IDLE;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mpq_pkg::S_IDLE;
			count_q   <= '0;
			ptr_q     <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			state_q   <= state_nxt;
			rvalid_s1 <= mem_re;
			if (req_fire) begin
				ptr_q <= '0;
			end else if (state_q == mpq_pkg::S_SCAN && pass_done) begin
				// Start the close-up just behind the winner
				ptr_q <= CW'(best_idx_q) + CW'(1);
			end else if (mem_re) begin
				ptr_q <= ptr_q + CW'(1);
			end
			if (res_fire) begin
				count_q <= count_nxt;
			end
		end
	end

	// Payload: request beat, read index and running maximum
	always_ff @(posedge clk) begin
		ridx_s1 <= mem_raddr;
		if (req_fire) begin
			key_q <= req.key;
			tag_q <= req.tag;
			if (req.opcode == mpq_pkg::OP_ENQUEUE) begin
				status_q <= (count_q == CW'(DEPTH)) ? mpq_pkg::ST_OVERFLOW
				                                    : mpq_pkg::ST_ENQUEUED;
			end else begin
				status_q <= (count_q == '0) ? mpq_pkg::ST_UNDERFLOW
				                            : mpq_pkg::ST_DEQUEUED;
			end
		end
		if (state_q == mpq_pkg::S_SCAN && take_best) begin
			best_q     <= mem_rdata;
			best_idx_q <= ridx_s1;
		end
	end

endmodule

// ===== rtl/max_priority_queue.sv =====
// Bounded max-priority queue of DEPTH entries, each a 16-bit key and a 16-bit tag, kept
// unsorted in arrival order in a single-port-write, registered-read memory. A request beat
// either appends an entry (enqueue) or removes the entry with the largest key (dequeue);
// among equal keys the oldest leaves first, and the entries behind it close up so arrival
// order is kept. Every request gives exactly one response beat with a status (enqueued,
// dequeued, underflow on empty, overflow on full), the removed key and tag (zero otherwise)
// and the occupancy after the operation. One request is worked on at a time. Enqueue,
// overflow and underflow go from idle straight to the response state and on through the
// output register. A dequeue runs a scan over the held entries, oldest first, one memory
// read and one key comparison per cycle, then a close-up of the entries behind the winner
// (none when the winner is the newest), one read and one write per cycle, then loads the
// response; both passes go through the one read port of the entry memory. The next request
// is taken while an earlier response still waits in the output register.
module max_priority_queue #(
	parameter int DEPTH = mpq_pkg::DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  mpq_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output mpq_pkg::rsp_t  rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int OW = mpq_pkg::OCC_W;

	logic             res_valid, res_ready;
	mpq_pkg::rsp_t    res;
	logic             mem_we, mem_re;
	logic [AW-1:0]    mem_waddr, mem_raddr;
	mpq_pkg::entry_t  mem_wdata, mem_rdata;
	logic             rsp_valid_q;
	mpq_pkg::rsp_t    rsp_q;

	mpq_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	mpq_store #(
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Output register: load a finished response when the slot is free or draining
	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// One request at a time: no second beat straight after an accepted one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one still in work");

	// Underflow only on an empty queue, with nothing removed
	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == mpq_pkg::ST_UNDERFLOW |->
			rsp.occupancy == '0 && rsp.out_key == '0 && rsp.out_tag == '0)
		else $error("underflow reported on a non-empty queue");

	// Overflow only on a full queue
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == mpq_pkg::ST_OVERFLOW |->
			rsp.occupancy == OW'(DEPTH) && rsp.out_key == '0 && rsp.out_tag == '0)
		else $error("overflow reported on a queue that is not full");

	// A finished response is never dropped while the output slot is busy
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("finished response lost while output stalled");
`endif

endmodule

// ===== dv/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QDEPTH = mpq_pkg::DEPTH_DEF;
	localparam int OW = mpq_pkg::OCC_W;
	localparam int RANDOM_BEATS = 1300;
	localparam int DRAIN_EVERY = 300;
	localparam int TAIL_CYCLES = 2 * QDEPTH + 20;

	// One line of the directed table: the request and, where it is plain, its response
	typedef struct packed {
		mpq_pkg::req_t stim;
		logic typed;
		mpq_pkg::rsp_t want;
	} dir_row_t;

	localparam mpq_pkg::rsp_t FROM_PREDICTOR = '0;

	localparam dir_row_t DIRECTED_ROWS [25] = '{
		// empty queue, payload ignored
		'{'{mpq_pkg::OP_DEQUEUE, 16'hffff, 16'hffff}, 1'b1,
			'{mpq_pkg::ST_UNDERFLOW, 16'h0000, 16'h0000, 5'd0}},
		'{'{mpq_pkg::OP_ENQUEUE, 16'h0000, 16'h0000}, 1'b1,
			'{mpq_pkg::ST_ENQUEUED, 16'h0000, 16'h0000, 5'd1}},
		'{'{mpq_pkg::OP_ENQUEUE, 16'hffff, 16'hffff}, 1'b1,
			'{mpq_pkg::ST_ENQUEUED, 16'h0000, 16'h0000, 5'd2}},
		'{'{mpq_pkg::OP_ENQUEUE, 16'hffff, 16'h1234}, 1'b1,
			'{mpq_pkg::ST_ENQUEUED, 16'h0000, 16'h0000, 5'd3}},
		// equal largest keys: the older one leaves first
		'{'{mpq_pkg::OP_DEQUEUE, 16'h0000, 16'h0000}, 1'b1,
			'{mpq_pkg::ST_DEQUEUED, 16'hffff, 16'hffff, 5'd2}},
		'{'{mpq_pkg::OP_DEQUEUE, 16'ha5a5, 16'h5a5a}, 1'b1,
			'{mpq_pkg::ST_DEQUEUED, 16'hffff, 16'h1234, 5'd1}},
		'{'{mpq_pkg::OP_DEQUEUE, 16'h5a5a, 16'ha5a5}, 1'b1,
			'{mpq_pkg::ST_DEQUEUED, 16'h0000, 16'h0000, 5'd0}},
		'{'{mpq_pkg::OP_DEQUEUE, 16'h0000, 16'hffff}, 1'b1,
			'{mpq_pkg::ST_UNDERFLOW, 16'h0000, 16'h0000, 5'd0}},
		// fill to capacity
		'{'{mpq_pkg::OP_ENQUEUE, 16'h0001, 16'hc001}, 1'b0, FROM_PREDICTOR},
		'{'{mpq_pkg::OP_ENQUEUE, 16'h8000, 16'hc002}, 1'b0, FROM_PREDICTOR},
		'{'{mpq_pkg::OP_ENQUEUE, 16'h7fff, 16'h0003}, 1'b0, FROM_PREDICTOR},
		'{'{mpq_pkg::OP_ENQUEUE, 16'h5555, 16'haaaa}, 1'b0, FROM_PREDICTOR},
		'{'{mpq_pkg::OP_ENQUEUE, 16'haaaa, 16'h5555}, 1'b0, FROM_PREDICTOR},
		'{'{mpq_pkg::OP_ENQUEUE, 16'h8000, 16'h8006}, 1'b0, FROM_PREDICTOR},
		'{'{mpq_pkg::OP_ENQUEUE, 16'h0000, 16'hffff}, 1'b0, FROM_PREDICTOR},
		'{'{mpq_pkg::OP_ENQUEUE, 16'hffff, 16'h0008}, 1'b0, FROM_PREDICTOR},
		'{'{mpq_pkg::OP_ENQUEUE, 16'h00ff, 16'hff00}, 1'b0, FROM_PREDICTOR},
		'{'{mpq_pkg::OP_ENQUEUE, 16'hff00, 16'h00ff}, 1'b0, FROM_PREDICTOR},
		'{'{mpq_pkg::OP_ENQUEUE, 16'h1234, 16'hedcb}, 1'b0, FROM_PREDICTOR},
		'{'{mpq_pkg::OP_ENQUEUE, 16'hfedc, 16'h0123}, 1'b0, FROM_PREDICTOR},
		'{'{mpq_pkg::OP_ENQUEUE, 16'h8000, 16'h800d}, 1'b0, FROM_PREDICTOR},
		'{'{mpq_pkg::OP_ENQUEUE, 16'h0f0f, 16'hf0f0}, 1'b0, FROM_PREDICTOR},
		'{'{mpq_pkg::OP_ENQUEUE, 16'hf0f0, 16'h0f0f}, 1'b0, FROM_PREDICTOR},
		'{'{mpq_pkg::OP_ENQUEUE, 16'hffff, 16'h0010}, 1'b0, FROM_PREDICTOR},
		// full queue refuses the entry
		'{'{mpq_pkg::OP_ENQUEUE, 16'h4321, 16'h8765}, 1'b1,
			'{mpq_pkg::ST_OVERFLOW, 16'h0000, 16'h0000, 5'd16}}
	};

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	mpq_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	mpq_pkg::rsp_t rsp;

	// Shadow of the held entries, oldest first, and the responses still to arrive
	mpq_pkg::entry_t held_entries[$];
	mpq_pkg::rsp_t awaited_rsps[$];
	int mismatches = 0;
	int idle_mode = 1;
	int rsp_stall_left = 0;

	max_priority_queue #(
		.DEPTH(QDEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatches++;
	endtask

	// Apply one request to the shadow queue and return the response it must give
	function automatic mpq_pkg::rsp_t serve_request(input mpq_pkg::req_t r);
		mpq_pkg::rsp_t o;
		mpq_pkg::entry_t e;
		int best;
		o = '0;
		if (r.opcode == mpq_pkg::OP_ENQUEUE) begin
			if (held_entries.size() >= QDEPTH) begin
				o.status = mpq_pkg::ST_OVERFLOW;
			end else begin
				e.key = r.key;
				e.tag = r.tag;
				held_entries.push_back(e);
				o.status = mpq_pkg::ST_ENQUEUED;
			end
		end else if (held_entries.size() == 0) begin
			o.status = mpq_pkg::ST_UNDERFLOW;
		end else begin
			best = 0;
			for (int i = 1; i < held_entries.size(); i++) begin
				if (held_entries[i].key > held_entries[best].key)
					best = i;
			end
			o.out_key = held_entries[best].key;
			o.out_tag = held_entries[best].tag;
			held_entries.delete(best);
			o.status = mpq_pkg::ST_DEQUEUED;
		end
		o.occupancy = OW'(held_entries.size());
		return o;
	endfunction

	// Gap before a request beat: mostly none or short, now and then long
	function automatic int draw_gap();
		int unsigned roll;
		roll = $urandom_range(99);
		if (idle_mode == 0)
			return 0;
		if (idle_mode == 1) begin
			if (roll < 70) return 0;
			if (roll < 95) return $urandom_range(3, 1);
			return $urandom_range(40, 8);
		end
		if (roll < 30) return 0;
		if (roll < 85) return $urandom_range(4, 1);
		return $urandom_range(40, 10);
	endfunction

	// Offer one request beat, hold it until taken, then record its response
	task automatic offer_beat(input mpq_pkg::req_t r, input int gap, input bit drain_first,
			input bit typed, input mpq_pkg::rsp_t want);
		mpq_pkg::rsp_t predicted;
		if (gap > 0 || drain_first) begin
			req_valid <= 1'b0;
			repeat (gap > 0 ? gap : 1) @(posedge clk);
			if (drain_first)
				while (awaited_rsps.size() != 0) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_ready !== 1'b1) @(posedge clk);
		predicted = serve_request(r);
		awaited_rsps.push_back(typed ? want : predicted);
	endtask

	// Response side stalls: runs of low ready, mostly short, a few long
	always @(posedge clk) begin : rsp_backpressure
		int unsigned roll;
		roll = $urandom_range(99);
		if (rsp_stall_left > 0) begin
			rsp_stall_left--;
			rsp_ready <= 1'b0;
		end else if (idle_mode == 0 || roll >= (idle_mode == 1 ? 20 : 50)) begin
			rsp_ready <= 1'b1;
		end else begin
			rsp_stall_left = ($urandom_range(99) < 85) ? $urandom_range(2) : $urandom_range(50, 10);
			rsp_ready <= 1'b0;
		end
	end

	// Check each response beat against the oldest one awaited
	always @(posedge clk) begin : rsp_check
		mpq_pkg::rsp_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
			if (awaited_rsps.size() == 0) begin
				report_mismatch($sformatf("response beat %0h with none awaited", rsp));
			end else begin
				want = awaited_rsps.pop_front();
				if (rsp.status !== want.status)
					report_mismatch($sformatf("status got %0d want %0d",
						rsp.status, want.status));
				if (rsp.out_key !== want.out_key)
					report_mismatch($sformatf("out_key got %h want %h",
						rsp.out_key, want.out_key));
				if (rsp.out_tag !== want.out_tag)
					report_mismatch($sformatf("out_tag got %h want %h",
						rsp.out_tag, want.out_tag));
				if (rsp.occupancy !== want.occupancy)
					report_mismatch($sformatf("occupancy got %0d want %0d",
						rsp.occupancy, want.occupancy));
			end
		end
	end

	// Stimulus: directed table, then random bursts of varying enqueue bias
	initial begin : stimulus
		mpq_pkg::req_t r;
		int burst_left;
		int enq_pct;
		int unsigned roll;
		burst_left = 0;
		enq_pct = 50;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		for (int i = 0; i < $size(DIRECTED_ROWS); i++)
			offer_beat(DIRECTED_ROWS[i].stim, draw_gap(), 1'b0,
				DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

		for (int n = 0; n < RANDOM_BEATS; n++) begin
			// pick a new bias and idling level per burst
			if (burst_left == 0) begin
				burst_left = $urandom_range(60, 20);
				idle_mode = $urandom_range(2);
				case ($urandom_range(3))
					0: enq_pct = 85;
					1: enq_pct = 15;
					2: enq_pct = 50;
					default: enq_pct = 60;
				endcase
			end
			burst_left--;

			r.opcode = ($urandom_range(99) < enq_pct) ? mpq_pkg::OP_ENQUEUE
			                                         : mpq_pkg::OP_DEQUEUE;
			roll = $urandom_range(99);
			// full range, a few tie-prone values, or a narrow band
			if (roll < 40) begin
				r.key = 16'($urandom_range(16'hffff));
			end else if (roll < 70) begin
				case ($urandom_range(4))
					0: r.key = 16'h0000;
					1: r.key = 16'h0001;
					2: r.key = 16'h7fff;
					3: r.key = 16'h8000;
					default: r.key = 16'hffff;
				endcase
			end else begin
				r.key = 16'($urandom_range(15));
			end
			r.tag = 16'($urandom_range(16'hffff));

			// hold off now and then until every response is home
			offer_beat(r, draw_gap(), (n % DRAIN_EVERY) == 0, 1'b0, FROM_PREDICTOR);
		end

		// drain and settle
		req_valid <= 1'b0;
		while (awaited_rsps.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	// Abort a run that hangs
	initial begin
		#4_000_000;
		$display("testbench failed");
		$finish;
	end

endmodule
